// File: rtl/plsc_pkg.sv
// plsc_pkg: character classes, token type and keyword tables for the
// property line syntax checker; used by plsc_front, plsc_back and the top level
package plsc_pkg;

   localparam int ClassWidth = 5;
   typedef logic [ClassWidth-1:0] char_class_type;

   // character classes made by the front end
   localparam char_class_type CL_OTHER  = 5'd0;
   localparam char_class_type CL_EOL    = 5'd1;
   localparam char_class_type CL_NUL    = 5'd2;
   localparam char_class_type CL_BLANK  = 5'd3;
   localparam char_class_type CL_SPACE  = 5'd4;
   localparam char_class_type CL_DOT    = 5'd5;
   localparam char_class_type CL_LPAREN = 5'd6;
   localparam char_class_type CL_RPAREN = 5'd7;
   localparam char_class_type CL_EQ     = 5'd8;
   localparam char_class_type CL_SQUOTE = 5'd9;
   localparam char_class_type CL_DQUOTE = 5'd10;
   localparam char_class_type CL_D      = 5'd11;
   localparam char_class_type CL_T      = 5'd12;
   localparam char_class_type CL_X      = 5'd13;
   localparam char_class_type CL_S      = 5'd14;
   localparam char_class_type CL_I      = 5'd15;
   localparam char_class_type CL_COLON  = 5'd16;
   localparam char_class_type CL_N      = 5'd17;
   localparam char_class_type CL_L      = 5'd18;
   // never produced by the classifier
   localparam char_class_type CL_NONE   = 5'd31;

   localparam int KwPosWidth = 3;
   localparam logic [KwPosWidth-1:0] KW_XSI_LAST = 3'd6;

   typedef struct packed {
      char_class_type char_class;
      logic           last;
   } token_type;

   function automatic char_class_type classify(input logic [7:0] b);
      char_class_type c;
      unique case (b) inside
         8'h00: c = CL_NUL;
         8'h0A, 8'h0D: c = CL_EOL;
         [8'h01:8'h09], 8'h0B, 8'h0C, [8'h0E:8'h1F]: c = CL_BLANK;
         8'h20: c = CL_SPACE;
         8'h2E: c = CL_DOT;
         8'h28: c = CL_LPAREN;
         8'h29: c = CL_RPAREN;
         8'h3D: c = CL_EQ;
         8'h27: c = CL_SQUOTE;
         8'h22: c = CL_DQUOTE;
         8'h64: c = CL_D;
         8'h74: c = CL_T;
         8'h78: c = CL_X;
         8'h73: c = CL_S;
         8'h69: c = CL_I;
         8'h3A: c = CL_COLON;
         8'h6E: c = CL_N;
         8'h6C: c = CL_L;
         default: c = CL_OTHER;
      endcase
      return c;
   endfunction

   // expected class at each position of xsi:nil after the leading x
   function automatic char_class_type xsi_expect(input logic [KwPosWidth-1:0] pos);
      char_class_type c;
      unique case (pos)
         3'd1: c = CL_S;
         3'd2: c = CL_I;
         3'd3: c = CL_COLON;
         3'd4: c = CL_N;
         3'd5: c = CL_I;
         3'd6: c = CL_L;
         default: c = CL_NONE;
      endcase
      return c;
   endfunction

endpackage

// File: rtl/plsc_queue.sv
// plsc_queue: two-entry first-in first-out queue of a generic payload
// depends on nothing else
module plsc_queue #(
   parameter int Width = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [Width-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [Width-1:0] pop_data,
   output logic             empty
);

   logic [1:0]       count_ff, count_in;
   logic [Width-1:0] slot0_ff, slot0_in;
   logic [Width-1:0] slot1_ff, slot1_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = slot0_ff;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      case ({do_push, do_pop})
         2'b10: begin
            if (count_ff == 2'd0) begin
               slot0_in = push_data;
            end else begin
               slot1_in = push_data;
            end
            count_in = count_ff + 2'd1;
         end
         2'b01: begin
            slot0_in = slot1_ff;
            count_in = count_ff - 2'd1;
         end
         2'b11: begin
            if (count_ff == 2'd1) begin
               slot0_in = push_data;
            end else begin
               slot0_in = slot1_ff;
               slot1_in = push_data;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

// File: rtl/plsc_front.sv
// plsc_front: classifies each incoming byte and queues the token for the back end
// depends on plsc_pkg and plsc_queue
module plsc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  logic [7:0]          req_text_byte,
   input  logic                req_last_byte,
   output logic                req_full,
   input  logic                tok_pop,
   output logic                tok_valid,
   output plsc_pkg::token_type tok
);
   import plsc_pkg::*;

   token_type                 new_tok;
   logic                      tok_empty;
   logic [$bits(token_type)-1:0] head_bits;

   assign new_tok.char_class = classify(req_text_byte);
   assign new_tok.last       = req_last_byte;

   plsc_queue #(
      .Width($bits(token_type))
   ) u_tok_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .push_data(new_tok),
      .full     (req_full),
      .pop      (tok_pop),
      .pop_data (head_bits),
      .empty    (tok_empty)
   );

   assign tok       = token_type'(head_bits);
   assign tok_valid = !tok_empty;

endmodule

// File: rtl/plsc_back.sv
// plsc_back: line grammar state machine over classified tokens, with the
// verdict queue on the result side; depends on plsc_pkg and plsc_queue
module plsc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                tok_valid,
   input  plsc_pkg::token_type tok,
   output logic                tok_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic                rsp_text_valid
);
   import plsc_pkg::*;

   localparam logic [3:0] PH_NAME       = 4'd0;
   localparam logic [3:0] PH_ATTR       = 4'd1;
   localparam logic [3:0] PH_KW_DT      = 4'd2;
   localparam logic [3:0] PH_KW_XSI     = 4'd3;
   localparam logic [3:0] PH_DT_SEP     = 4'd4;
   localparam logic [3:0] PH_DT_WS      = 4'd5;
   localparam logic [3:0] PH_DT_VSTART  = 4'd6;
   localparam logic [3:0] PH_DT_UNQ     = 4'd7;
   localparam logic [3:0] PH_DT_QUOTE   = 4'd8;
   localparam logic [3:0] PH_CLOSE      = 4'd9;
   localparam logic [3:0] PH_XSI_SEP    = 4'd10;
   localparam logic [3:0] PH_XSI_WS     = 4'd11;
   localparam logic [3:0] PH_XSI_VSTART = 4'd12;
   localparam logic [3:0] PH_XSI_VAL    = 4'd13;
   localparam logic [3:0] PH_DONE       = 4'd14;
   localparam logic [3:0] PH_FAILED     = 4'd15;

   logic [3:0]            phase_ff, phase_in;
   logic [KwPosWidth-1:0] kw_pos_ff, kw_pos_in;
   logic                  dquote_ff, dquote_in;
   logic                  ended_ff, ended_in;
   logic                  out_full;
   logic                  verdict;
   logic                  blank;
   char_class_type        cls;

   function automatic logic [3:0] line_end(input logic [3:0] ph);
      return (ph == PH_NAME || ph == PH_DONE) ? PH_NAME : PH_FAILED;
   endfunction

   assign cls     = tok.char_class;
   assign blank   = (cls == CL_BLANK) || (cls == CL_SPACE);
   // a last token waits only for room in the verdict queue
   assign tok_pop = tok_valid && (!tok.last || !out_full);

   always_comb begin
      phase_in  = phase_ff;
      kw_pos_in = kw_pos_ff;
      dquote_in = dquote_ff;
      ended_in  = ended_ff;
      verdict   = 1'b0;
      if (tok_pop) begin
         if (!ended_ff) begin
            if (cls == CL_NUL) begin
               phase_in = line_end(phase_ff);
               ended_in = 1'b1;
            end else if (cls == CL_EOL) begin
               phase_in = line_end(phase_ff);
            end else begin
               unique case (phase_ff)
                  PH_NAME: begin
                     if (cls == CL_DOT) begin
                        phase_in = PH_FAILED;
                     end else if (cls == CL_LPAREN) begin
                        phase_in = PH_ATTR;
                     end
                  end
                  PH_ATTR: begin
                     if (cls == CL_D) begin
                        kw_pos_in = 3'd1;
                        phase_in  = PH_KW_DT;
                     end else if (cls == CL_X) begin
                        kw_pos_in = 3'd1;
                        phase_in  = PH_KW_XSI;
                     end else if (!blank) begin
                        phase_in = PH_FAILED;
                     end
                  end
                  PH_KW_DT: begin
                     kw_pos_in = 3'd0;
                     phase_in  = (cls == CL_T) ? PH_DT_SEP : PH_FAILED;
                  end
                  PH_KW_XSI: begin
                     if (cls != xsi_expect(kw_pos_ff)) begin
                        phase_in = PH_FAILED;
                     end else if (kw_pos_ff == KW_XSI_LAST) begin
                        kw_pos_in = 3'd0;
                        phase_in  = PH_XSI_SEP;
                     end else begin
                        kw_pos_in = kw_pos_ff + 3'd1;
                     end
                  end
                  PH_DT_SEP: begin
                     if (cls == CL_EQ) begin
                        phase_in = PH_DT_VSTART;
                     end else if (cls == CL_SPACE) begin
                        phase_in = PH_DT_WS;
                     end else begin
                        phase_in = PH_FAILED;
                     end
                  end
                  PH_XSI_SEP: begin
                     if (cls == CL_EQ) begin
                        phase_in = PH_XSI_VSTART;
                     end else if (cls == CL_SPACE) begin
                        phase_in = PH_XSI_WS;
                     end else begin
                        phase_in = PH_FAILED;
                     end
                  end
                  PH_DT_WS: begin
                     if (cls == CL_EQ) begin
                        phase_in = PH_DT_VSTART;
                     end else if (!blank) begin
                        phase_in = PH_FAILED;
                     end
                  end
                  PH_XSI_WS: begin
                     if (cls == CL_EQ) begin
                        phase_in = PH_XSI_VSTART;
                     end else if (!blank) begin
                        phase_in = PH_FAILED;
                     end
                  end
                  PH_DT_VSTART: begin
                     if (cls == CL_SQUOTE || cls == CL_DQUOTE) begin
                        dquote_in = (cls == CL_DQUOTE);
                        phase_in  = PH_DT_QUOTE;
                     end else if (cls == CL_RPAREN) begin
                        phase_in = PH_DONE;
                     end else if (cls == CL_EQ) begin
                        phase_in = PH_FAILED;
                     end else if (!blank) begin
                        phase_in = PH_DT_UNQ;
                     end
                  end
                  PH_DT_UNQ: begin
                     if (blank) begin
                        phase_in = PH_CLOSE;
                     end else if (cls == CL_RPAREN) begin
                        phase_in = PH_DONE;
                     end else if (cls == CL_EQ) begin
                        phase_in = PH_FAILED;
                     end
                  end
                  PH_DT_QUOTE: begin
                     if (cls == (dquote_ff ? CL_DQUOTE : CL_SQUOTE)) begin
                        phase_in = PH_CLOSE;
                     end
                  end
                  PH_CLOSE: begin
                     if (cls == CL_RPAREN) begin
                        phase_in = PH_DONE;
                     end else if (!blank) begin
                        phase_in = PH_FAILED;
                     end
                  end
                  PH_XSI_VSTART: begin
                     if (cls == CL_RPAREN) begin
                        phase_in = PH_DONE;
                     end else if (!blank) begin
                        phase_in = PH_XSI_VAL;
                     end
                  end
                  PH_XSI_VAL: begin
                     if (cls == CL_RPAREN) begin
                        phase_in = PH_DONE;
                     end else if (blank) begin
                        phase_in = PH_FAILED;
                     end
                  end
                  PH_DONE: begin
                  end
                  default: begin
                     phase_in = PH_FAILED;
                  end
               endcase
            end
         end
         if (tok.last) begin
            // closing the open line leaves the verdict set by name or done
            verdict   = (phase_in == PH_NAME) || (phase_in == PH_DONE);
            phase_in  = PH_NAME;
            kw_pos_in = 3'd0;
            dquote_in = 1'b0;
            ended_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_NAME;
         kw_pos_ff <= 3'd0;
         dquote_ff <= 1'b0;
         ended_ff  <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         kw_pos_ff <= kw_pos_in;
         dquote_ff <= dquote_in;
         ended_ff  <= ended_in;
      end
   end

   plsc_queue #(
      .Width(1)
   ) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (tok_pop && tok.last),
      .push_data(verdict),
      .full     (out_full),
      .pop      (rsp_pop),
      .pop_data (rsp_text_valid),
      .empty    (rsp_empty)
   );

endmodule

// File: rtl/property_line_syntax_checker.sv
// One byte of property text is taken per clock cycle while req_full is low; the
// byte marked last yields a single verdict (1 = every line passed). A byte is
// classified on entry and queued in a two-entry token queue; the line grammar
// state machine then steps once per cycle while a token waits and may be taken,
// and a verdict is registered in the result queue as its last token is taken.
// Up to two verdicts wait in the result queue; while it is full, a further
// last byte holds in the token queue and input is refused once that fills.
// depends on plsc_pkg, plsc_front, plsc_back
module property_line_syntax_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_text_byte,
   input  logic       req_last_byte,
   output logic       req_full,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_text_valid
);
   import plsc_pkg::*;

   token_type tok;
   logic      tok_valid;
   logic      tok_pop;

   plsc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_text_byte(req_text_byte),
      .req_last_byte(req_last_byte),
      .req_full     (req_full),
      .tok_pop      (tok_pop),
      .tok_valid    (tok_valid),
      .tok          (tok)
   );

   plsc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .tok_valid     (tok_valid),
      .tok           (tok),
      .tok_pop       (tok_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_text_valid(rsp_text_valid)
   );

endmodule

// File: rtl/plsc_checker.sv
// plsc_checker: port-level checks of the property line syntax checker,
// bound to the top level; depends on nothing else
module plsc_checker (
   input logic clock,
   input logic reset,
   input logic req_push,
   input logic req_last_byte,
   input logic req_full,
   input logic rsp_empty,
   input logic rsp_pop,
   input logic rsp_text_valid
);

   // texts whose last byte went in and whose verdict is not yet taken
   logic [2:0] pending_ff, pending_in;
   logic       last_in_xfer, rsp_xfer;

   assign last_in_xfer = req_push && !req_full && req_last_byte;
   assign rsp_xfer     = rsp_pop && !rsp_empty;
   assign pending_in   = pending_ff + {2'b00, last_in_xfer} - {2'b00, rsp_xfer};

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 3'd0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty)
      else $error("waiting result withdrawn");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> $stable(rsp_text_valid))
      else $error("waiting verdict changed");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not cleared by reset");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> pending_ff != 3'd0)
      else $error("verdict without a finished text");

endmodule

bind property_line_syntax_checker plsc_checker u_plsc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_push      (req_push),
   .req_last_byte (req_last_byte),
   .req_full      (req_full),
   .rsp_empty     (rsp_empty),
   .rsp_pop       (rsp_pop),
   .rsp_text_valid(rsp_text_valid)
);
